[hw/rtl/cpr_pkg.sv]
// Shared types and constants of the clock page replacement unit.
// Used by cpr_ctrl, cpr_datapath and clock_page_replacement_unit; no dependencies.
package cpr_pkg;

  localparam int ENTRIES   = 1024;
  localparam int LAP_LIMIT = 3;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int PROBES    = LAP_LIMIT * ENTRIES;
  localparam int PRB_W     = $clog2(PROBES);
  localparam int INDEX_W   = 10;

  // entry flag bit positions
  localparam int FLAG_SETUP_BIT = 0;
  localparam int FLAG_RES_BIT   = 1;
  localparam int FLAG_REF_BIT   = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FIND  = 1'b1
  } opcode_t;

  typedef enum logic {
    STS_OK   = 1'b0,
    STS_FAIL = 1'b1
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic                set_up_flag;
    logic                resident_flag;
    logic                referenced_flag;
  } req_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  victim_index;
    status_t             status;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_FIND_RD,
    ST_PROBE,
    ST_POST
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic latch_in;
    logic do_write;
    logic find_start;
    logic probe;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_find;
    logic hit;
    logic last_probe;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/cpr_datapath.sv]
// Datapath: flag table memory, clock hand, probe counter and response register.
// Depends on cpr_pkg; driven by cpr_ctrl through cmd_t / sts_t.
module cpr_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cpr_pkg::cmd_t     cmd,
  output cpr_pkg::sts_t     sts,
  input  cpr_pkg::req_word_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cpr_pkg::rsp_word_t rsp
);
  import cpr_pkg::*;

  logic [2:0]         mem [ENTRIES];
  logic [2:0]         rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [2:0]         wr_data;

  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   hand;
  logic [IDX_W-1:0]   hand_adv;
  logic [PRB_W-1:0]   probe_cnt;
  logic [INDEX_W-1:0] lat_idx;
  logic [2:0]         lat_flags;
  rsp_word_t          res;

  logic eligible;
  logic hit;
  logic last_probe;

  assign hand_adv   = (hand == IDX_W'(ENTRIES - 1)) ? '0 : hand + 1'b1;
  assign eligible   = rd_data[FLAG_SETUP_BIT] & rd_data[FLAG_RES_BIT];
  assign hit        = eligible & ~rd_data[FLAG_REF_BIT];
  assign last_probe = (probe_cnt == PRB_W'(PROBES - 1));

  // one write port: clear sweep, entry write, or referenced-bit update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hand;
    wr_data = rd_data;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.do_write) begin
      wr_en   = (int'(lat_idx) < ENTRIES);
      wr_addr = IDX_W'(lat_idx);
      wr_data = lat_flags;
    end else if (cmd.probe) begin
      // referenced set -> clear it; clear -> set it (victim)
      wr_en                 = eligible;
      wr_data[FLAG_REF_BIT] = ~rd_data[FLAG_REF_BIT];
    end
  end

  // read ahead one entry so a probe completes every cycle
  assign rd_en   = cmd.find_start | (cmd.probe & ~hit);
  assign rd_addr = cmd.find_start ? hand : hand_adv;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      hand      <= '0;
      probe_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.find_start) begin
        probe_cnt <= '0;
      end else if (cmd.probe) begin
        probe_cnt <= probe_cnt + 1'b1;
      end
      if (cmd.probe && !hit) begin
        hand <= hand_adv;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      lat_idx   <= req.entry_index;
      lat_flags <= {req.referenced_flag, req.resident_flag, req.set_up_flag};
    end
    if (cmd.do_write) begin
      res.victim_index <= '0;
      res.status       <= STS_OK;
    end else if (cmd.probe && hit) begin
      res.victim_index <= INDEX_W'(hand);
      res.status       <= STS_OK;
    end else if (cmd.probe && last_probe) begin
      res.victim_index <= '0;
      res.status       <= STS_FAIL;
    end
    if (cmd.load_out) begin
      rsp <= res;
    end
  end

  assign sts.clr_done   = (clr_addr == IDX_W'(ENTRIES - 1));
  assign sts.is_find    = (req.opcode == OP_FIND);
  assign sts.hit        = hit;
  assign sts.last_probe = last_probe;
  assign sts.out_free   = ~rsp_valid | rsp_ready;

  a_no_rsp_while_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !rsp_valid)
    else $error("response valid during table clear");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("response register overwritten before it was taken");

  a_hand_stays_on_victim: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe && hit) |=> (hand == $past(hand)))
    else $error("hand moved off the victim entry");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STS_FAIL) |-> (rsp.victim_index == '0))
    else $error("failed find reports a nonzero index");

endmodule

[hw/rtl/cpr_ctrl.sv]
// Controller state machine: clear sweep, request intake, write, probe walk, response.
// Depends on cpr_pkg; commands cpr_datapath through cmd_t / sts_t.
module cpr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cpr_pkg::sts_t sts,
  output cpr_pkg::cmd_t cmd
);
  import cpr_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = sts.is_find ? ST_FIND_RD : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.do_write = 1'b1;
        state_next   = ST_POST;
      end
      ST_FIND_RD: begin
        cmd.find_start = 1'b1;
        state_next     = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.hit || sts.last_probe) state_next = ST_POST;
      end
      ST_POST: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/clock_page_replacement_unit.sv]
// Top level of the clock (second-chance) page replacement unit.
// Depends on cpr_pkg, cpr_ctrl and cpr_datapath.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one word per operation:
//   opcode write stores the three flag bits of entry_index; opcode find
//   walks the table from the clock hand and picks a victim.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one word per
//   request, in order: victim_index and status (fail after three laps).
// Sequence from accept to rsp_valid (ST_POST loads the response register):
//   write: ST_WRITE stores the flags, then ST_POST.
//   find : ST_FIND_RD, then ST_PROBE for n entries (1 .. LAP_LIMIT*ENTRIES,
//          i.e. up to 3072), then ST_POST. One probe per cycle, set by the
//          single read and single write port of the flag memory, with the
//          next entry read ahead while the current one is checked and updated.
//   One request is in progress at a time; the next is taken once the
//   previous response sits in the output register.
// Reset: rst clears the hand and starts a sweep that zeroes all ENTRIES
//   flag entries, one per cycle; req_ready stays low until the sweep is
//   done.
// Stall: a response waiting in the output register does not block the
//   next request; a second response waits inside until rsp_ready frees it.
module clock_page_replacement_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cpr_pkg::req_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cpr_pkg::rsp_word_t  rsp
);
  import cpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing only: states, handshake, commands
  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // flag memory, hand, probe count, response register
  cpr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Testbench for clock_page_replacement_unit: directed and random write/find words,
// each response checked against a second-chance victim predictor. Depends on cpr_pkg.

module testbench;
  import cpr_pkg::*;

  localparam int RANDOM_WORDS = 172;
  localparam int HOLD_CYCLES  = 4000;
  localparam int REQ_W        = $bits(req_word_t);
  // Worst legal gap: a find that misses (3072 probes) plus the hold-off, or the
  // clear sweep after reset.
  localparam int IDLE_LIMIT   = 40000;

  // Tracks the flag table and clock hand, keeps the expected responses in order.
  class victim_tracker;
    logic [2:0] flags [ENTRIES];
    int         hand;
    rsp_word_t  expected_rsp [$];
    int         errors;
    int         writes;
    int         finds;
    int         misses;

    function new();
      foreach (flags[i]) flags[i] = '0;
      hand   = 0;
      errors = 0;
      writes = 0;
      finds  = 0;
      misses = 0;
    endfunction

    // Second-chance walk from the hand; the hand stays on the victim.
    function rsp_word_t pick_victim();
      rsp_word_t  r;
      logic [2:0] f;
      r.victim_index = '0;
      r.status       = STS_FAIL;
      for (int n = 0; n < PROBES; n++) begin
        f = flags[hand];
        if (f[FLAG_SETUP_BIT] && f[FLAG_RES_BIT]) begin
          if (f[FLAG_REF_BIT]) begin
            flags[hand][FLAG_REF_BIT] = 1'b0;
          end else begin
            flags[hand][FLAG_REF_BIT] = 1'b1;
            r.victim_index = INDEX_W'(hand);
            r.status       = STS_OK;
            return r;
          end
        end
        hand = (hand == ENTRIES - 1) ? 0 : hand + 1;
      end
      // full laps walked: hand is back where it started
      return r;
    endfunction

    function void note_request(req_word_t w);
      rsp_word_t  r;
      logic [2:0] f;
      r.victim_index = '0;
      r.status       = STS_OK;
      if (w.opcode == OP_WRITE) begin
        writes++;
        if (int'(w.entry_index) < ENTRIES) begin
          f                 = '0;
          f[FLAG_SETUP_BIT] = w.set_up_flag;
          f[FLAG_RES_BIT]   = w.resident_flag;
          f[FLAG_REF_BIT]   = w.referenced_flag;
          flags[w.entry_index] = f;
        end
      end else begin
        finds++;
        r = pick_victim();
        if (r.status == STS_FAIL) misses++;
      end
      expected_rsp.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_response(rsp_word_t got);
      rsp_word_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("response idx=%0d status=%s with no request waiting",
                         got.victim_index, got.status.name()));
        return;
      end
      want = expected_rsp.pop_front();
      if (got.victim_index !== want.victim_index)
        report($sformatf("victim_index got %0d want %0d",
                         got.victim_index, want.victim_index));
      if (got.status !== want.status)
        report($sformatf("status got %s want %s", got.status.name(), want.status.name()));
    endtask
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_word_t rsp;

  victim_tracker tracker;
  int rsp_count = 0;
  bit calm      = 1'b0;   // no idling on either side while set
  bit held      = 1'b0;   // long response hold-off already done

  clock_page_replacement_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor: outputs are sampled at the edge, before any update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) tracker.note_request(req);
      if (rsp_valid && rsp_ready) begin
        tracker.check_response(rsp);
        rsp_count <= rsp_count + 1;
      end
    end
  end

  // Offer one word. valid is dropped only for a gap, so a back-to-back word
  // never sees valid lowered and raised in the same step.
  task automatic send_word(input req_word_t w);
    if (!calm && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic write_entry(input int idx, input bit s, input bit r, input bit f);
    req_word_t w;
    w.opcode          = OP_WRITE;
    w.entry_index     = INDEX_W'(idx);
    w.set_up_flag     = s;
    w.resident_flag   = r;
    w.referenced_flag = f;
    send_word(w);
  endtask

  // Non-opcode fields are junk on a find; the block must ignore them.
  task automatic find_victim();
    req_word_t w;
    w                 = req_word_t'(REQ_W'($urandom));
    w.opcode          = OP_FIND;
    send_word(w);
  endtask

  // Response side: random stalls, plus one long hold-off once traffic is
  // flowing so the output register and the internal slot both fill and
  // req_ready drops while the sender keeps offering.
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && rsp_count >= 30) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    req_word_t w;
    int        pick;
    tracker = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    find_victim();                  // empty table: three laps, no victim
    write_entry(0, 1, 1, 0);        // lowest index, candidate
    write_entry(1023, 1, 1, 1);     // highest index, referenced
    write_entry(5, 0, 1, 1);        // resident but not set up: skipped
    write_entry(6, 1, 0, 1);        // set up but not resident: skipped
    find_victim();                  // entry 0 at the hand
    find_victim();                  // second chance for 0 and 1023, wraps back to 0
    write_entry(1023, 1, 1, 0);
    find_victim();                  // victim at the top index
    write_entry(0, 0, 0, 0);
    write_entry(1023, 0, 0, 1);
    find_victim();                  // nothing resident: miss, hand unchanged
    write_entry(341, 1, 1, 1);      // alternating index bit patterns
    write_entry(682, 1, 1, 1);
    find_victim();                  // clears both, wraps, picks 341
    write_entry(7, 1, 1, 1);
    find_victim();
    write_entry(682, 0, 0, 0);
    find_victim();

    // --- random: mostly well-formed writes/finds, some raw noise words ---
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      calm = (k >= 60 && k < 110);
      pick = $urandom_range(99);
      if (pick < 8) begin
        w = req_word_t'(REQ_W'($urandom));
      end else if (pick < 50) begin
        w        = req_word_t'(REQ_W'($urandom));
        w.opcode = OP_FIND;
      end else begin
        w.opcode      = OP_WRITE;
        // half the writes land in a small hot window so finds hit often
        w.entry_index = $urandom_range(1) ? INDEX_W'($urandom_range(0, ENTRIES - 1))
                                          : INDEX_W'($urandom_range(0, 31));
        if ($urandom_range(99) < 70) begin
          w.set_up_flag   = 1'b1;
          w.resident_flag = 1'b1;
        end else begin
          w.set_up_flag   = 1'($urandom_range(1));
          w.resident_flag = 1'($urandom_range(1));
        end
        w.referenced_flag = 1'($urandom_range(1));
      end
      send_word(w);
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // drain, then give a stray response time to show up
    while (tracker.expected_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Run covered %0d writes and %0d finds (%0d found no victim),",
             tracker.writes, tracker.finds, tracker.misses);
    $display("with random stalls on both channels and a %0d-cycle response hold-off.",
             HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
